// File: rtl/pdf_pkg.sv
`timescale 1ns / 1ps
package pdf_pkg;

  localparam int ValueW    = 16;
  localparam int WidthW    = 4;
  localparam int CharW     = 8;
  localparam int DigitW    = 4;
  localparam int MaxDigits = 5;
  localparam int DigIdxW   = 3;

  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiMinus = 8'h2D;

  // 2^19 / 10 rounded up; exact quotient for dividends below 43699
  localparam logic [ValueW-1:0] RecipTen = 16'd52429;
  localparam int                RecipSh  = 19;

endpackage

// File: rtl/pdf_if.sv
`timescale 1ns / 1ps
interface pdf_in_if
  import pdf_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic [WidthW-1:0]        min_width;
  logic [CharW-1:0]         pad_char;

  modport source (output valid, value, min_width, pad_char, input ready);
  modport sink   (input valid, value, min_width, pad_char, output ready);
endinterface

interface pdf_out_if
  import pdf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

// File: rtl/pdf_div10.sv
`timescale 1ns / 1ps
module pdf_div10
  import pdf_pkg::*;
(
  input  logic [ValueW-1:0] dividend,
  output logic [ValueW-1:0] quotient,
  output logic [DigitW-1:0] remainder
);

  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   q_times_ten;
  logic [ValueW-1:0]   diff;

  // Multiply by the scaled reciprocal and keep the high bits
  assign prod     = dividend * RecipTen;
  assign quotient = ValueW'(prod[2*ValueW-1:RecipSh]);

  // Remainder: dividend minus quotient times ten (8q + 2q)
  assign q_times_ten = (quotient << 3) + (quotient << 1);
  assign diff        = dividend - q_times_ten;
  assign remainder   = diff[DigitW-1:0];

endmodule

// File: rtl/padded_decimal_formatter_unit.sv
`timescale 1ns / 1ps
// Signed 16-bit integer to padded decimal ASCII.
// request channel: one item carries value, min_width and pad_char. The unit
// takes a request only while idle (ready high), then works on it alone.
// result channel: one character per transfer, most significant first: pad
// characters (min_width minus digit count, if positive), a '-' for negative
// values, then the digits. last marks the final character of a number.
// min_width saturates at MAX_CHARS-1 (valid range of MAX_CHARS: 7 to 16).
// Operation: after the accept, the shared divide-by-ten unit extracts one digit
// per cycle (1 to 5 digits), then one character per cycle, while the receiver
// does not stall, is loaded into the output register (1 to MAX_CHARS chars).
// Request ready rises again once the last character is loaded.
// The output register holds a character until the receiver takes it; a
// stalled receiver stops the character sequencer. The last character stays
// in the output register while the next request is accepted.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending character.
module padded_decimal_formatter_unit
  import pdf_pkg::*;
#(
  parameter int MAX_CHARS = 10
) (
  input  logic      clk,
  input  logic      rst,
  pdf_in_if.sink    request,
  pdf_out_if.source result
);

  localparam int CntW     = $clog2(MAX_CHARS);
  localparam int WidthCap = MAX_CHARS - 1;

  typedef enum logic [2:0] {
    IDLE,
    DIVIDE,
    PAD,
    SIGN,
    DIGITS
  } state_t;

  state_t              state;
  logic [ValueW-1:0]   mag;
  logic                negative;
  logic [CntW-1:0]     width;
  logic [CharW-1:0]    pad;
  logic [DigitW-1:0]   digits [MaxDigits];
  logic [DigIdxW-1:0]  ndig;
  logic [CntW-1:0]     pad_cnt;
  logic                out_valid;
  logic [CharW-1:0]    out_char;
  logic                out_last;

  logic [ValueW-1:0]   quot;
  logic [DigitW-1:0]   rem;
  logic [DigIdxW-1:0]  ndig_next;
  logic [CntW-1:0]     ndig_ext;
  logic                out_free;
  logic                out_load;
  logic [DigitW-1:0]   cur_digit;

  pdf_div10 u_div10 (
    .dividend  (mag),
    .quotient  (quot),
    .remainder (rem)
  );

  assign ndig_next = ndig + DigIdxW'(1);
  assign ndig_ext  = CntW'(ndig_next);
  assign out_free  = !out_valid || result.ready;
  assign out_load  = out_free && (state inside {PAD, SIGN, DIGITS});
  assign cur_digit = digits[ndig - DigIdxW'(1)];

  assign request.ready   = (state == IDLE);
  assign result.valid    = out_valid;
  assign result.out_char = out_char;
  assign result.last     = out_last;

  // Sequence one request: divide, then emit pads, sign and digits
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new character, or drop the current one once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (request.valid) begin
            negative <= request.value[ValueW-1];
            mag      <= request.value[ValueW-1] ? (~request.value + ValueW'(1))
                                                : request.value;
            if (int'(request.min_width) > WidthCap) begin
              width <= CntW'(WidthCap);
            end else begin
              width <= CntW'(request.min_width);
            end
            pad   <= request.pad_char;
            ndig  <= '0;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          digits[ndig] <= rem;
          mag          <= quot;
          ndig         <= ndig_next;
          if (quot == '0) begin
            if (width > ndig_ext) begin
              pad_cnt <= width - ndig_ext;
              state   <= PAD;
            end else if (negative) begin
              state <= SIGN;
            end else begin
              state <= DIGITS;
            end
          end
        end
        PAD: begin
          if (out_free) begin
            out_char  <= pad;
            out_last  <= 1'b0;
            pad_cnt   <= pad_cnt - CntW'(1);
            if (pad_cnt == CntW'(1)) begin
              state <= negative ? SIGN : DIGITS;
            end
          end
        end
        SIGN: begin
          if (out_free) begin
            out_char  <= AsciiMinus;
            out_last  <= 1'b0;
            state     <= DIGITS;
          end
        end
        DIGITS: begin
          if (out_free) begin
            out_char  <= AsciiZero + CharW'(cur_digit);
            out_last  <= (ndig == DigIdxW'(1));
            ndig      <= ndig - DigIdxW'(1);
            if (ndig == DigIdxW'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pdf_pkg::*;

  localparam int MaxChars = 10;
  localparam int WidthCap = MaxChars - 1;
  localparam int NumRandom = 100;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [WidthW-1:0]        min_width;
    logic [CharW-1:0]         pad_char;
    bit                       drain_first;
  } num_req_t;

  typedef struct {
    logic [CharW-1:0] out_char;
    logic             last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdf_in_if  req_if ();
  pdf_out_if res_if ();

  padded_decimal_formatter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .request(req_if),
    .result (res_if)
  );

  num_req_t   pending_reqs[$];
  text_char_t expected_text[$];
  int         fail_count = 0;
  bit         req_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         stall_mode = 0;
  int         cycle_cnt = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Append the characters one request should produce to the expected text
  function automatic void predict_text(num_req_t r);
    logic             negative;
    logic [16:0]      mag;
    logic [3:0]       digs[MaxDigits];
    int               ndig;
    int               width;
    text_char_t       line[$];
    text_char_t       c;

    negative = r.value[ValueW-1];
    mag = negative ? (17'h10000 - {1'b0, r.value}) : {1'b0, r.value};
    width = (r.min_width > WidthCap) ? WidthCap : int'(r.min_width);
    ndig = 0;
    do begin
      digs[ndig] = 4'(mag % 10);
      ndig++;
      mag = mag / 10;
    end while (mag != 0);
    c.last = 1'b0;
    for (int i = 0; i < width - ndig; i++) begin
      c.out_char = r.pad_char;
      line.push_back(c);
    end
    if (negative) begin
      c.out_char = AsciiMinus;
      line.push_back(c);
    end
    for (int i = ndig; i > 0; i--) begin
      c.out_char = AsciiZero + {4'd0, digs[i-1]};
      line.push_back(c);
    end
    line[line.size()-1].last = 1'b1;
    foreach (line[i]) expected_text.push_back(line[i]);
  endfunction

  task automatic add_request(int v, int w, int pad, bit drain = 1'b0);
    num_req_t r;
    r.value = 16'(v);
    r.min_width = 4'(w);
    r.pad_char = 8'(pad);
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endtask

  // Track both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        num_req_t r;
        r.value = req_if.value;
        r.min_width = req_if.min_width;
        r.pad_char = req_if.pad_char;
        r.drain_first = 1'b0;
        predict_text(r);
        void'(pending_reqs.pop_front());
        req_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h (last %b)", res_if.out_char, res_if.last);
          fail_count++;
        end else begin
          text_char_t e;
          e = expected_text.pop_front();
          if (res_if.out_char !== e.out_char) begin
            $error("out_char: expected %h, got %h", e.out_char, res_if.out_char);
            fail_count++;
          end
          if (res_if.last !== e.last) begin
            $error("last: expected %b, got %b", e.last, res_if.last);
            fail_count++;
          end
        end
      end
    end
  end

  // Drive requests in bursts and stall the result side at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      // hold a request that has not been taken yet
      if (!req_if.valid || req_taken) begin
        if (gap_left > 0) begin
          req_if.valid <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_text.size() != 0)) begin
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid     <= 1'b1;
          req_if.value     <= pending_reqs[0].value;
          req_if.min_width <= pending_reqs[0].min_width;
          req_if.pad_char  <= pending_reqs[0].pad_char;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      req_taken = 1'b0;

      // switch the stall pattern now and then
      cycle_cnt++;
      if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        case (stall_mode)
          1: stall_left = $urandom_range(0, 1);
          2: stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : 0;
          3: stall_left = $urandom_range(0, 6);
          default: stall_left = 0;
        endcase
      end
    end
  end

  initial begin
    int mag;
    int v;
    int lo;
    int hi;
    int d;
    int w;
    int pad;

    req_if.valid = 1'b0;
    req_if.value = '0;
    req_if.min_width = '0;
    req_if.pad_char = '0;
    res_if.ready = 1'b0;

    // directed: extremes, padding edges, width saturation, pad codes
    add_request(0, 0, 8'h30);
    add_request(0, 9, 8'h20);
    add_request(32767, 0, 8'h2A);
    add_request(-32768, 0, 8'h20);
    add_request(-32768, 9, 8'h30);
    add_request(-1, 3, 8'h20);
    add_request(1, 1, 8'h20);
    add_request(12345, 5, 8'h2A);
    add_request(12345, 6, 8'h00);
    add_request(12345, 4, 8'h20);
    add_request(7, 10, 8'h23);
    add_request(7, 15, 8'h23);
    add_request(-7, 12, 8'hFF);
    add_request(-9, 2, 8'h5F);
    add_request(9, 0, 8'h20);
    add_request(10, 3, 8'h30);
    add_request(99, 2, 8'h20);
    add_request(100, 8, 8'hAA);
    add_request(9999, 9, 8'h55);
    add_request(10000, 1, 8'h20);
    add_request(-10000, 7, 8'h2E);
    add_request(-99, 15, 8'h30);

    // random: mixed magnitudes, mostly in-range widths
    for (int i = 0; i < NumRandom; i++) begin
      case ($urandom_range(0, 5))
        1: v = $urandom_range(0, 20);
        2: begin
          d = $urandom_range(1, 5);
          lo = (d == 1) ? 0 : 10 ** (d - 1);
          hi = (d == 5) ? 32767 : 10 ** d - 1;
          v = $urandom_range(lo, hi);
        end
        3: begin
          case ($urandom_range(0, 5))
            0: v = 32767;
            1: v = -32768;
            2: v = 0;
            3: v = 9999;
            4: v = 10000;
            default: v = 99999;
          endcase
        end
        default: v = int'($signed(16'($urandom)));
      endcase
      if ($urandom_range(0, 1) == 1 && v > 0 && v <= 32768) v = -v;
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: pad = 8'h20;
        1: pad = 8'h30;
        default: pad = $urandom_range(0, 255);
      endcase
      add_request(v, w, pad, (i % 40) == 0);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || expected_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/pdf_pkg.sv
rtl/pdf_if.sv
rtl/pdf_div10.sv
rtl/padded_decimal_formatter_unit.sv
tb/tb_top.sv
